// File: design/tmpu_pkg.sv
// Package with shared types, constants and status codes of the tag matching engine.
package tmpu_pkg;

    localparam int DEF_POSTED_DEPTH = 16;
    localparam int DEF_UNEXP_DEPTH  = 16;
    localparam int DEF_HANDLE_BITS  = 8;

    localparam int BITS_W   = 64;
    localparam int LEN_W    = 32;
    localparam int HND_W    = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED_POSTED = 3'd0,
        ST_MATCHED       = 3'd1,
        ST_QUEUED_UNEXP  = 3'd2,
        ST_BAD_MASK      = 3'd3,
        ST_NO_SPACE      = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming transaction
        logic update;   // apply the queue change and register the result
    } t_dp_cmd;

endpackage

// File: design/tmpu_if.sv
// Valid/ready channel interfaces for the input and the result transactions.
interface tmpu_in_if;
    import tmpu_pkg::*;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BITS_W-1:0] match_bits;
    logic [BITS_W-1:0] mask_bits;
    logic [LEN_W-1:0]  length;
    logic [HND_W-1:0]  handle;
    modport source (output valid, mode, match_bits, mask_bits, length, handle, input ready);
    modport sink   (input valid, mode, match_bits, mask_bits, length, handle, output ready);
endinterface

interface tmpu_out_if;
    import tmpu_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HND_W-1:0]    partner_handle;
    logic [LEN_W-1:0]    copy_length;
    logic [LEN_W-1:0]    full_length;
    logic                truncated;
    modport source (output valid, status, partner_handle, copy_length, full_length, truncated,
                    input ready);
    modport sink   (input valid, status, partner_handle, copy_length, full_length, truncated,
                    output ready);
endinterface

// File: design/tmpu_datapath.sv
// Datapath: both queues, parallel compare, priority pick, compaction and the result register.
module tmpu_datapath #(
    parameter int POSTED_DEPTH = tmpu_pkg::DEF_POSTED_DEPTH,
    parameter int UNEXP_DEPTH  = tmpu_pkg::DEF_UNEXP_DEPTH,
    parameter int HANDLE_BITS  = tmpu_pkg::DEF_HANDLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tmpu_pkg::t_dp_cmd               i_cmd,
    input  logic                            i_mode,
    input  logic [tmpu_pkg::BITS_W-1:0]     i_match_bits,
    input  logic [tmpu_pkg::BITS_W-1:0]     i_mask_bits,
    input  logic [tmpu_pkg::LEN_W-1:0]      i_length,
    input  logic [tmpu_pkg::HND_W-1:0]      i_handle,
    output logic [tmpu_pkg::STATUS_W-1:0]   o_status,
    output logic [tmpu_pkg::HND_W-1:0]      o_partner_handle,
    output logic [tmpu_pkg::LEN_W-1:0]      o_copy_length,
    output logic [tmpu_pkg::LEN_W-1:0]      o_full_length,
    output logic                            o_truncated
);
    import tmpu_pkg::*;

    localparam int PC_W = $clog2(POSTED_DEPTH + 1);
    localparam int UC_W = $clog2(UNEXP_DEPTH + 1);
    localparam int PI_W = (POSTED_DEPTH > 1) ? $clog2(POSTED_DEPTH) : 1;
    localparam int UI_W = (UNEXP_DEPTH > 1) ? $clog2(UNEXP_DEPTH) : 1;

    // Queue storage, kept oldest first.
    logic [BITS_W-1:0]      r_p_bits [POSTED_DEPTH];
    logic [BITS_W-1:0]      r_p_mask [POSTED_DEPTH];
    logic [LEN_W-1:0]       r_p_len  [POSTED_DEPTH];
    logic [HANDLE_BITS-1:0] r_p_hnd  [POSTED_DEPTH];
    logic [PC_W-1:0]        r_p_cnt;
    logic [BITS_W-1:0]      r_u_bits [UNEXP_DEPTH];
    logic [LEN_W-1:0]       r_u_len  [UNEXP_DEPTH];
    logic [HANDLE_BITS-1:0] r_u_hnd  [UNEXP_DEPTH];
    logic [UC_W-1:0]        r_u_cnt;

    // Captured transaction.
    logic                   r_mode;
    logic [BITS_W-1:0]      r_bits;
    logic [BITS_W-1:0]      r_mask;
    logic [LEN_W-1:0]       r_len;
    logic [HANDLE_BITS-1:0] r_hnd;

    // Registered hit vectors from the parallel compare.
    logic [POSTED_DEPTH-1:0] r_p_hit;
    logic [UNEXP_DEPTH-1:0]  r_u_hit;

    // Capture the transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_bits <= i_match_bits;
            r_mask <= i_mask_bits;
            r_len  <= i_length;
            r_hnd  <= HANDLE_BITS'(i_handle);
        end
    end

    // Compare every live entry against the incoming transaction as it is captured.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < POSTED_DEPTH; k++) begin
                r_p_hit[k] <= (PC_W'(k) < r_p_cnt) &&
                              (r_p_bits[k] == (r_p_mask[k] & i_match_bits));
            end
            for (int k = 0; k < UNEXP_DEPTH; k++) begin
                r_u_hit[k] <= (UC_W'(k) < r_u_cnt) &&
                              ((r_u_bits[k] & i_mask_bits) == i_match_bits);
            end
        end
    end

    // Priority pick of the oldest hit in each queue.
    logic            p_any, u_any;
    logic [PI_W-1:0] p_idx;
    logic [UI_W-1:0] u_idx;
    always_comb begin
        p_any = 1'b0;
        p_idx = '0;
        for (int k = POSTED_DEPTH - 1; k >= 0; k--) begin
            if (r_p_hit[k]) begin
                p_any = 1'b1;
                p_idx = PI_W'(k);
            end
        end
        u_any = 1'b0;
        u_idx = '0;
        for (int k = UNEXP_DEPTH - 1; k >= 0; k--) begin
            if (r_u_hit[k]) begin
                u_any = 1'b1;
                u_idx = UI_W'(k);
            end
        end
    end

    // Decide the outcome of the transaction.
    logic                   bad_mask, do_match, rm_p, rm_u, add_p, add_u;
    logic [STATUS_W-1:0]    status;
    logic [LEN_W-1:0]       buf_len, msg_len, xfer;
    logic [HANDLE_BITS-1:0] partner;
    always_comb begin
        bad_mask = !r_mode && ((r_bits & ~r_mask) != '0);
        rm_u     = !r_mode && !bad_mask && u_any;
        rm_p     = r_mode && p_any;
        do_match = rm_u || rm_p;
        add_p    = !r_mode && !bad_mask && !u_any && (r_p_cnt < PC_W'(POSTED_DEPTH));
        add_u    = r_mode && !p_any && (r_u_cnt < UC_W'(UNEXP_DEPTH));
        buf_len  = r_mode ? r_p_len[p_idx] : r_len;
        msg_len  = r_mode ? r_len : r_u_len[u_idx];
        partner  = r_mode ? r_p_hnd[p_idx] : r_u_hnd[u_idx];
        xfer     = (buf_len < msg_len) ? buf_len : msg_len;
        if (bad_mask) begin
            status = ST_BAD_MASK;
        end else if (do_match) begin
            status = ST_MATCHED;
        end else if (add_p) begin
            status = ST_QUEUED_POSTED;
        end else if (add_u) begin
            status = ST_QUEUED_UNEXP;
        end else begin
            status = ST_NO_SPACE;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_status         <= status;
            o_partner_handle <= do_match ? HND_W'(partner) : '0;
            o_copy_length    <= do_match ? xfer : '0;
            o_full_length    <= do_match ? msg_len : '0;
            o_truncated      <= do_match && (xfer < msg_len);
        end
    end

    // Posted queue: compact on removal, append at the tail.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            for (int k = 0; k < POSTED_DEPTH; k++) begin
                if (rm_p && (PI_W'(k) >= p_idx) && (k + 1 < POSTED_DEPTH)) begin
                    r_p_bits[k] <= r_p_bits[(k + 1) % POSTED_DEPTH];
                    r_p_mask[k] <= r_p_mask[(k + 1) % POSTED_DEPTH];
                    r_p_len[k]  <= r_p_len[(k + 1) % POSTED_DEPTH];
                    r_p_hnd[k]  <= r_p_hnd[(k + 1) % POSTED_DEPTH];
                end else if (add_p && (PC_W'(k) == r_p_cnt)) begin
                    r_p_bits[k] <= r_bits;
                    r_p_mask[k] <= r_mask;
                    r_p_len[k]  <= r_len;
                    r_p_hnd[k]  <= r_hnd;
                end
            end
        end
    end

    // Unexpected queue: compact on removal, append at the tail.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            for (int k = 0; k < UNEXP_DEPTH; k++) begin
                if (rm_u && (UI_W'(k) >= u_idx) && (k + 1 < UNEXP_DEPTH)) begin
                    r_u_bits[k] <= r_u_bits[(k + 1) % UNEXP_DEPTH];
                    r_u_len[k]  <= r_u_len[(k + 1) % UNEXP_DEPTH];
                    r_u_hnd[k]  <= r_u_hnd[(k + 1) % UNEXP_DEPTH];
                end else if (add_u && (UC_W'(k) == r_u_cnt)) begin
                    r_u_bits[k] <= r_bits;
                    r_u_len[k]  <= r_len;
                    r_u_hnd[k]  <= r_hnd;
                end
            end
        end
    end

    // Fill counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_cnt <= '0;
            r_u_cnt <= '0;
        end else if (i_cmd.update) begin
            if (rm_p) begin
                r_p_cnt <= r_p_cnt - 1'b1;
            end else if (add_p) begin
                r_p_cnt <= r_p_cnt + 1'b1;
            end
            if (rm_u) begin
                r_u_cnt <= r_u_cnt - 1'b1;
            end else if (add_u) begin
                r_u_cnt <= r_u_cnt + 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_p_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_cnt <= PC_W'(POSTED_DEPTH)) else $error("posted count overflow");
    a_u_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u_cnt <= UC_W'(UNEXP_DEPTH)) else $error("unexpected count overflow");
    a_one_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> !((rm_p || add_p) && (rm_u || add_u)))
        else $error("one transaction changed both queues");
    a_hit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && rm_p |-> (PC_W'(p_idx) < r_p_cnt))
        else $error("match taken from an empty posted slot");
`endif
endmodule

// File: design/tmpu_ctrl.sv
// Controller: sequences capture, compare and update, and holds the result handshake.
module tmpu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tmpu_pkg::t_dp_cmd o_cmd
);
    import tmpu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_COMPARE = 3'b010,
        S_OUTPUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Input is taken when idle, or when the pending result leaves this cycle.
    always_comb begin
        o_in_ready   = (r_state == S_IDLE) || ((r_state == S_OUTPUT) && i_out_ready);
        o_out_valid  = (r_state == S_OUTPUT);
        o_cmd.load   = o_in_ready && i_in_valid;
        o_cmd.update = (r_state == S_COMPARE);
        n_state      = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_COMPARE;
            end
            S_COMPARE: begin
                n_state = S_OUTPUT;
            end
            S_OUTPUT: begin
                if (i_out_ready) n_state = i_in_valid ? S_COMPARE : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_load_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_COMPARE)) else $error("load not followed by compare");
    a_compare_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPARE) |=> o_out_valid) else $error("result not presented");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
`endif
endmodule

// File: design/tag_match_posted_unexpected.sv
// Top level of the tag matching engine with posted and unexpected queues.
//
// Channels: in_ch carries post (mode 0) and arrival (mode 1) transactions;
// out_ch returns exactly one result transaction for each input transaction.
// Both use valid/ready; a transaction moves when both are high at a clock edge.
// Sequence: the edge that accepts an input also registers a parallel compare of
// every queue entry against it. In the next cycle the oldest hit is picked, the
// queue compacts or appends and the result is registered, so the result is
// valid once it is registered and stays valid until it is taken.
// No new input is taken during that compare/update sequence; a new input is
// accepted in the same cycle that the previous result is taken.
// Reset (synchronous, active low) empties both queues and the result stage;
// no clearing pass is needed.
// When the receiver stalls, the result is held and no further input is taken
// until it leaves.
module tag_match_posted_unexpected #(
    parameter int POSTED_DEPTH = tmpu_pkg::DEF_POSTED_DEPTH,
    parameter int UNEXP_DEPTH  = tmpu_pkg::DEF_UNEXP_DEPTH,
    parameter int HANDLE_BITS  = tmpu_pkg::DEF_HANDLE_BITS
) (
    input logic  i_clk,
    input logic  i_rst_n,
    tmpu_in_if.sink    in_ch,
    tmpu_out_if.source out_ch
);
    import tmpu_pkg::*;

    t_dp_cmd cmd;

    // Control sequencer.
    tmpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .o_cmd       (cmd)
    );

    // Queues and match logic.
    tmpu_datapath #(
        .POSTED_DEPTH (POSTED_DEPTH),
        .UNEXP_DEPTH  (UNEXP_DEPTH),
        .HANDLE_BITS  (HANDLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_mode           (in_ch.mode),
        .i_match_bits     (in_ch.match_bits),
        .i_mask_bits      (in_ch.mask_bits),
        .i_length         (in_ch.length),
        .i_handle         (in_ch.handle),
        .o_status         (out_ch.status),
        .o_partner_handle (out_ch.partner_handle),
        .o_copy_length    (out_ch.copy_length),
        .o_full_length    (out_ch.full_length),
        .o_truncated      (out_ch.truncated)
    );
endmodule
